// ===== hdl/first_fit_heap_block_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// first fit heap block table - assertion macros
// shared property forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_BLOCK_TABLE_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_BLOCK_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define FFHB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffhb assertion failed");

// next-cycle implication
`define FFHB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffhb assertion failed");

`endif

// ===== hdl/ffhb_pkg.sv =====
// ----------------------------------------------------------------------------
// ffhb_pkg
// types and codes shared by the heap block table files
// ----------------------------------------------------------------------------
package ffhb_pkg;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 24;
   localparam int CMD_W  = 3;
   localparam int HSEL_W = 2;
   localparam int ST_W   = 3;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_HEAPS = 3;

   localparam logic [ADDR_W-1:0] ALIGN_LOW = 32'd15;

   localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LARGEST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FREE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_VOID    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SHRINK  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_NOFIT    = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [ST_W-1:0] ST_STATE    = 3'd4;

   localparam logic [1:0] KIND_FREE = 2'd0;
   localparam logic [1:0] KIND_VOID = 2'd1;
   localparam logic [1:0] KIND_USED = 2'd2;

   localparam int FLAG_FAILED = 0;
   localparam int FLAG_VOIDED = 1;

   localparam logic [CFG_IDX_W-1:0] CFG_BASE0 = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_SIZE0 = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_BASE1 = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_SIZE1 = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_BASE2 = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_SIZE2 = 3'd5;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [1:0]        kind;
   } entry_type;

   typedef struct packed {
      logic [CFG_HEAPS-1:0][ADDR_W-1:0] base;
      logic [CFG_HEAPS-1:0][SIZE_W-1:0] size;
   } cfg_type;

   function automatic logic [ADDR_W-1:0] round16(input logic [ADDR_W-1:0] v);
      round16 = (v + ALIGN_LOW) & ~ALIGN_LOW;
   endfunction

endpackage

// ===== hdl/ffhb_req_if.sv =====
// ----------------------------------------------------------------------------
// ffhb_req_if
// command channel: valid, ready and one command
// ----------------------------------------------------------------------------
interface ffhb_req_if;
   logic                           valid;
   logic                           ready;
   logic [ffhb_pkg::CMD_W-1:0]     cmd;
   logic [ffhb_pkg::HSEL_W-1:0]    heap_select;
   logic [ffhb_pkg::SIZE_W-1:0]    req_size;
   logic [ffhb_pkg::ADDR_W-1:0]    block_addr;

   modport source (output valid, cmd, heap_select, req_size, block_addr, input ready);
   modport sink   (input valid, cmd, heap_select, req_size, block_addr, output ready);
endinterface

// ===== hdl/ffhb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffhb_rsp_if
// response channel: valid, ready, address and status
// ----------------------------------------------------------------------------
interface ffhb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ffhb_pkg::ADDR_W-1:0]  result_addr;
   logic [ffhb_pkg::ST_W-1:0]    status;

   modport source (output valid, result_addr, status, input ready);
   modport sink   (input valid, result_addr, status, output ready);
endinterface

// ===== hdl/ffhb_ram.sv =====
// ----------------------------------------------------------------------------
// ffhb_ram
// simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module ffhb_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ffhb_csr.sv =====
// ----------------------------------------------------------------------------
// ffhb_csr
// heap base and size registers behind the write-only port
// ----------------------------------------------------------------------------
module ffhb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ffhb_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [ffhb_pkg::ADDR_W-1:0]      csr_wdata,
   output ffhb_pkg::cfg_type                cfg
);

   ffhb_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ffhb_pkg::CFG_BASE0: cfg_in.base[0] = csr_wdata;
            ffhb_pkg::CFG_SIZE0: cfg_in.size[0] = csr_wdata[ffhb_pkg::SIZE_W-1:0];
            ffhb_pkg::CFG_BASE1: cfg_in.base[1] = csr_wdata;
            ffhb_pkg::CFG_SIZE1: cfg_in.size[1] = csr_wdata[ffhb_pkg::SIZE_W-1:0];
            ffhb_pkg::CFG_BASE2: cfg_in.base[2] = csr_wdata;
            ffhb_pkg::CFG_SIZE2: cfg_in.size[2] = csr_wdata[ffhb_pkg::SIZE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/first_fit_heap_block_table_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_block_table_core
// multi-heap first fit allocator over address-sorted block tables
// ----------------------------------------------------------------------------
// channel | dir | handshake     | payload
// req_ch  | in  | valid / ready | cmd, heap_select, req_size, block_addr
// rsp_ch  | out | valid / ready | result_addr, status
// csr_*   | in  | csr_we        | csr_index, csr_wdata
//
// one command at a time; each table access is a read of the block ram with
// a registered result, read one entry at a time by the sequencer.
// alloc scans the entries and then shifts entries up to split a block;
// alloc largest scans twice; free/void/shrink run a binary search, after
// which free pulls entries down and shrink shifts them up; clear folds.
// reset is synchronous; the block ram needs no clearing since every heap is
// written by init before any entry is read. a held response does not stop
// the next command from starting, only from finishing.
// ----------------------------------------------------------------------------
`include "first_fit_heap_block_table_core_assert.svh"

module first_fit_heap_block_table_core #(
   parameter int MAX_UNITS = 256,
   parameter int NUM_HEAPS = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   ffhb_req_if.sink                        req_ch,
   ffhb_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [ffhb_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [ffhb_pkg::ADDR_W-1:0]     csr_wdata
);

   localparam int KW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int CW = KW + 1;
   localparam int HW = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
   localparam int DEPTH = NUM_HEAPS * MAX_UNITS;
   localparam int AW = $clog2(DEPTH);
   localparam int EW = $bits(ffhb_pkg::entry_type);
   localparam logic [AW-1:0] MU = AW'(MAX_UNITS);
   localparam logic [CW-1:0] CNT_FULL = CW'(MAX_UNITS - 1);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_INIT1  = 5'd2;
   localparam logic [4:0] S_SC_RD  = 5'd3;
   localparam logic [4:0] S_SC_WT  = 5'd4;
   localparam logic [4:0] S_OP_RD  = 5'd5;
   localparam logic [4:0] S_OP_WT  = 5'd6;
   localparam logic [4:0] S_OP_FIN = 5'd7;
   localparam logic [4:0] S_AL_USE = 5'd8;
   localparam logic [4:0] S_BS     = 5'd9;
   localparam logic [4:0] S_BS_WT  = 5'd10;
   localparam logic [4:0] S_FOUND  = 5'd11;
   localparam logic [4:0] S_FR_PW  = 5'd12;
   localparam logic [4:0] S_FR_NW  = 5'd13;
   localparam logic [4:0] S_DR_RD  = 5'd14;
   localparam logic [4:0] S_DR_WT  = 5'd15;
   localparam logic [4:0] S_SH_WT  = 5'd16;
   localparam logic [4:0] S_FD_RD  = 5'd17;
   localparam logic [4:0] S_FD_WT  = 5'd18;
   localparam logic [4:0] S_DONE   = 5'd19;

   ffhb_pkg::cfg_type cfg;

   ffhb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // table ram
   logic              wr_en, rd_en;
   logic [KW-1:0]     wr_k, rd_k;
   ffhb_pkg::entry_type wr_ent, rd_ent;
   logic [EW-1:0]     rd_word;
   logic [AW-1:0]     wr_addr, rd_addr;

   // state
   logic [4:0]        state_ff, state_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [1:0]        h_ff, h_in;
   logic [23:0]       req_ff, req_in;
   logic [31:0]       baddr_ff, baddr_in;
   logic [31:0]       size_ff, size_in;
   logic [CW-1:0]     idx_ff, idx_in;
   ffhb_pkg::entry_type prev_ff, prev_in;
   logic [31:0]       best_ff, best_in;
   logic              large_ff, large_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [31:0]       kstart_ff, kstart_in;
   logic [1:0]        kkind_ff, kkind_in;
   logic [31:0]       ins_ff, ins_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [CW-1:0]     a_ff, a_in, b_ff, b_in, m_ff, m_in;
   logic [31:0]       off_ff, off_in;
   logic              pfree_ff, pfree_in;
   logic [1:0]        n_ff, n_in;
   logic [CW-1:0]     w_ff, w_in;
   logic              run_ff, run_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic [2:0]        res_st_ff, res_st_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;
   logic [2:0]        rsp_st_ff, rsp_st_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]     cnt_ff   [NUM_HEAPS];
   logic [CW-1:0]     cnt_in   [NUM_HEAPS];
   logic [1:0]        flags_ff [NUM_HEAPS];
   logic [1:0]        flags_in [NUM_HEAPS];
   logic [31:0]       lo_ff    [NUM_HEAPS];
   logic [31:0]       lo_in    [NUM_HEAPS];
   logic [31:0]       hi_ff    [NUM_HEAPS];
   logic [31:0]       hi_in    [NUM_HEAPS];

   logic [HW-1:0]     hidx;
   logic              hvalid;
   logic              accept;
   logic [CW-1:0]     cnt;
   logic              full;
   logic [31:0]       len;
   logic [31:0]       bnew;
   logic [31:0]       heap_b, heap_s;
   logic [CW:0]       drop_src;

   assign hidx   = HW'(h_ff);
   assign hvalid = 32'(h_ff) < NUM_HEAPS;
   assign accept = req_ch.valid & req_ch.ready;
   assign cnt    = cnt_ff[hidx];
   assign full   = cnt >= CNT_FULL;
   assign len    = rd_ent.start - ((state_ff == S_SH_WT) ? kstart_ff : prev_ff.start);
   assign drop_src = (CW + 1)'(j_ff) + (CW + 1)'(n_ff);

   assign wr_addr = AW'(hidx) * MU + AW'(wr_k);
   assign rd_addr = AW'(hidx) * MU + AW'(rd_k);
   assign rd_ent  = ffhb_pkg::entry_type'(rd_word);

   ffhb_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_ent)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      heap_b = '0;
      heap_s = '0;
      case (h_ff)
         2'd0: begin
            heap_b = cfg.base[0];
            heap_s = {8'd0, cfg.size[0]} & ~ffhb_pkg::ALIGN_LOW;
         end
         2'd1: begin
            heap_b = cfg.base[1];
            heap_s = {8'd0, cfg.size[1]} & ~ffhb_pkg::ALIGN_LOW;
         end
         2'd2: begin
            heap_b = cfg.base[2];
            heap_s = {8'd0, cfg.size[2]} & ~ffhb_pkg::ALIGN_LOW;
         end
         default: begin
            heap_b = '0;
            heap_s = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;   cmd_in = cmd_ff;       h_in = h_ff;
      req_in = req_ff;       baddr_in = baddr_ff;   size_in = size_ff;
      idx_in = idx_ff;       prev_in = prev_ff;     best_in = best_ff;
      large_in = large_ff;   k_in = k_ff;           kstart_in = kstart_ff;
      kkind_in = kkind_ff;   ins_in = ins_ff;       j_in = j_ff;
      a_in = a_ff;           b_in = b_ff;           m_in = m_ff;
      off_in = off_ff;       pfree_in = pfree_ff;   n_in = n_ff;
      w_in = w_ff;           run_in = run_ff;
      res_addr_in = res_addr_ff;  res_st_in = res_st_ff;
      rsp_addr_in = rsp_addr_ff;  rsp_st_in = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      cnt_in = cnt_ff;  flags_in = flags_ff;  lo_in = lo_ff;  hi_in = hi_ff;
      wr_en = 1'b0;  wr_k = '0;  wr_ent = '0;
      rd_en = 1'b0;  rd_k = '0;
      bnew = best_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_ch.cmd;
               h_in = req_ch.heap_select;
               req_in = req_ch.req_size;
               baddr_in = req_ch.block_addr;
               res_addr_in = '0;
               res_st_in = ffhb_pkg::ST_OK;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            if (!hvalid) begin
               res_st_in = ffhb_pkg::ST_NOTFOUND;
            end else begin
               case (cmd_ff)
                  ffhb_pkg::CMD_INIT: begin
                     wr_en = 1'b1;
                     wr_k = '0;
                     wr_ent = '{start: heap_b, kind: ffhb_pkg::KIND_FREE};
                     flags_in[hidx] = '0;
                     lo_in[hidx] = heap_b;
                     hi_in[hidx] = heap_b + heap_s;
                     cnt_in[hidx] = CW'(1);
                     ins_in = heap_b + heap_s;
                     state_in = S_INIT1;
                  end
                  ffhb_pkg::CMD_ALLOC, ffhb_pkg::CMD_LARGEST: begin
                     size_in = ffhb_pkg::round16({8'd0, req_ff});
                     if (full) begin
                        res_st_in = ffhb_pkg::ST_FULL;
                     end else if (cnt == '0 || (cmd_ff == ffhb_pkg::CMD_ALLOC &&
                                  ffhb_pkg::round16({8'd0, req_ff}) == '0)) begin
                        res_st_in = ffhb_pkg::ST_NOFIT;
                        flags_in[hidx][ffhb_pkg::FLAG_FAILED] = 1'b1;
                     end else begin
                        idx_in = '0;
                        best_in = '0;
                        large_in = (cmd_ff == ffhb_pkg::CMD_LARGEST);
                        state_in = S_SC_RD;
                     end
                  end
                  ffhb_pkg::CMD_FREE, ffhb_pkg::CMD_VOID, ffhb_pkg::CMD_SHRINK: begin
                     off_in = baddr_ff - lo_ff[hidx];
                     if ((baddr_ff - lo_ff[hidx]) >= (hi_ff[hidx] - lo_ff[hidx])) begin
                        res_st_in = ffhb_pkg::ST_NOTFOUND;
                     end else begin
                        a_in = '0;
                        b_in = cnt;
                        state_in = S_BS;
                     end
                  end
                  ffhb_pkg::CMD_CLEAR: begin
                     if (flags_ff[hidx][ffhb_pkg::FLAG_VOIDED]) begin
                        idx_in = '0;
                        w_in = '0;
                        run_in = 1'b0;
                        state_in = S_FD_RD;
                     end else begin
                        flags_in[hidx] = '0;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_INIT1: begin
            wr_en = 1'b1;
            wr_k = KW'(1);
            wr_ent = '{start: ins_ff, kind: ffhb_pkg::KIND_USED};
            state_in = S_DONE;
         end
         S_SC_RD: begin
            rd_en = 1'b1;
            rd_k = idx_ff[KW-1:0];
            state_in = S_SC_WT;
         end
         S_SC_WT: begin
            if (idx_ff == '0) begin
               prev_in = rd_ent;
               idx_in = CW'(1);
               state_in = S_SC_RD;
            end else if (!large_ff && prev_ff.kind == ffhb_pkg::KIND_FREE &&
                         len >= size_ff) begin
               k_in = idx_ff - CW'(1);
               kstart_in = prev_ff.start;
               if (len > size_ff) begin
                  ins_in = prev_ff.start + size_ff;
                  j_in = cnt;
                  state_in = S_OP_RD;
               end else begin
                  state_in = S_AL_USE;
               end
            end else begin
               if (large_ff && prev_ff.kind == ffhb_pkg::KIND_FREE && len > best_ff) begin
                  bnew = len;
               end
               best_in = bnew;
               prev_in = rd_ent;
               if (idx_ff == cnt) begin
                  if (large_ff && ffhb_pkg::round16(bnew) != '0) begin
                     size_in = ffhb_pkg::round16(bnew);
                     large_in = 1'b0;
                     idx_in = '0;
                     state_in = S_SC_RD;
                  end else begin
                     res_st_in = ffhb_pkg::ST_NOFIT;
                     flags_in[hidx][ffhb_pkg::FLAG_FAILED] = 1'b1;
                     state_in = S_DONE;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1);
                  state_in = S_SC_RD;
               end
            end
         end
         // shift entries k+1 .. end marker up by one, top first
         S_OP_RD: begin
            if (j_ff > k_ff) begin
               rd_en = 1'b1;
               rd_k = j_ff[KW-1:0];
               state_in = S_OP_WT;
            end else begin
               state_in = S_OP_FIN;
            end
         end
         S_OP_WT: begin
            wr_en = 1'b1;
            wr_k = KW'(j_ff + CW'(1));
            wr_ent = rd_ent;
            j_in = j_ff - CW'(1);
            state_in = S_OP_RD;
         end
         S_OP_FIN: begin
            wr_en = 1'b1;
            wr_k = KW'(k_ff + CW'(1));
            wr_ent = '{start: ins_ff, kind: ffhb_pkg::KIND_FREE};
            cnt_in[hidx] = cnt + CW'(1);
            if (cmd_ff == ffhb_pkg::CMD_SHRINK) begin
               res_addr_in = ins_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_AL_USE;
            end
         end
         S_AL_USE: begin
            wr_en = 1'b1;
            wr_k = k_ff[KW-1:0];
            wr_ent = '{start: kstart_ff, kind: ffhb_pkg::KIND_USED};
            res_addr_in = kstart_ff;
            state_in = S_DONE;
         end
         S_BS: begin
            if (a_ff < b_ff) begin
               m_in = a_ff + ((b_ff - a_ff) >> 1);
               rd_en = 1'b1;
               rd_k = KW'(a_ff + ((b_ff - a_ff) >> 1));
               state_in = S_BS_WT;
            end else begin
               res_st_in = ffhb_pkg::ST_NOTFOUND;
               state_in = S_DONE;
            end
         end
         S_BS_WT: begin
            if ((rd_ent.start - lo_ff[hidx]) == off_ff) begin
               k_in = m_ff;
               kstart_in = rd_ent.start;
               kkind_in = rd_ent.kind;
               state_in = S_FOUND;
            end else begin
               if ((rd_ent.start - lo_ff[hidx]) < off_ff) begin
                  a_in = m_ff + CW'(1);
               end else begin
                  b_in = m_ff;
               end
               state_in = S_BS;
            end
         end
         S_FOUND: begin
            state_in = S_DONE;
            case (cmd_ff)
               ffhb_pkg::CMD_VOID: begin
                  wr_en = 1'b1;
                  wr_k = k_ff[KW-1:0];
                  wr_ent = '{start: kstart_ff, kind: ffhb_pkg::KIND_VOID};
                  flags_in[hidx][ffhb_pkg::FLAG_VOIDED] = 1'b1;
               end
               ffhb_pkg::CMD_FREE: begin
                  if (kkind_ff == ffhb_pkg::KIND_FREE) begin
                     res_st_in = ffhb_pkg::ST_STATE;
                  end else if (k_ff != '0) begin
                     rd_en = 1'b1;
                     rd_k = KW'(k_ff - CW'(1));
                     state_in = S_FR_PW;
                  end else begin
                     pfree_in = 1'b0;
                     rd_en = 1'b1;
                     rd_k = KW'(k_ff + CW'(1));
                     state_in = S_FR_NW;
                  end
               end
               ffhb_pkg::CMD_SHRINK: begin
                  if (kkind_ff != ffhb_pkg::KIND_USED) begin
                     res_st_in = ffhb_pkg::ST_STATE;
                  end else begin
                     size_in = ffhb_pkg::round16({8'd0, req_ff});
                     rd_en = 1'b1;
                     rd_k = KW'(k_ff + CW'(1));
                     state_in = S_SH_WT;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_FR_PW: begin
            pfree_in = (rd_ent.kind == ffhb_pkg::KIND_FREE);
            rd_en = 1'b1;
            rd_k = KW'(k_ff + CW'(1));
            state_in = S_FR_NW;
         end
         S_FR_NW: begin
            wr_en = 1'b1;
            wr_k = k_ff[KW-1:0];
            wr_ent = '{start: kstart_ff, kind: ffhb_pkg::KIND_FREE};
            n_in = {1'b0, pfree_ff} + {1'b0, rd_ent.kind == ffhb_pkg::KIND_FREE};
            j_in = pfree_ff ? k_ff : k_ff + CW'(1);
            if (!pfree_ff && rd_ent.kind != ffhb_pkg::KIND_FREE) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DR_RD;
            end
         end
         // pull entries down over the merged ones
         S_DR_RD: begin
            if (drop_src <= (CW + 1)'(cnt)) begin
               rd_en = 1'b1;
               rd_k = drop_src[KW-1:0];
               state_in = S_DR_WT;
            end else begin
               cnt_in[hidx] = cnt - CW'(n_ff);
               state_in = S_DONE;
            end
         end
         S_DR_WT: begin
            wr_en = 1'b1;
            wr_k = j_ff[KW-1:0];
            wr_ent = rd_ent;
            j_in = j_ff + CW'(1);
            state_in = S_DR_RD;
         end
         S_SH_WT: begin
            state_in = S_DONE;
            if (size_ff == '0 || size_ff >= len) begin
               res_st_in = ffhb_pkg::ST_NOFIT;
            end else if (full) begin
               res_st_in = ffhb_pkg::ST_FULL;
            end else begin
               ins_in = kstart_ff + size_ff;
               j_in = cnt;
               state_in = S_OP_RD;
            end
         end
         S_FD_RD: begin
            if (idx_ff < cnt) begin
               rd_en = 1'b1;
               rd_k = idx_ff[KW-1:0];
               state_in = S_FD_WT;
            end else begin
               wr_en = 1'b1;
               wr_k = w_ff[KW-1:0];
               wr_ent = '{start: hi_ff[hidx], kind: ffhb_pkg::KIND_USED};
               cnt_in[hidx] = w_ff;
               flags_in[hidx] = '0;
               state_in = S_DONE;
            end
         end
         S_FD_WT: begin
            wr_k = w_ff[KW-1:0];
            if (rd_ent.kind == ffhb_pkg::KIND_USED) begin
               wr_en = 1'b1;
               wr_ent = '{start: rd_ent.start, kind: ffhb_pkg::KIND_USED};
               w_in = w_ff + CW'(1);
               run_in = 1'b0;
            end else if (!run_ff) begin
               wr_en = 1'b1;
               wr_ent = '{start: rd_ent.start, kind: ffhb_pkg::KIND_FREE};
               w_in = w_ff + CW'(1);
               run_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
            state_in = S_FD_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_addr_in = res_addr_ff;
               rsp_st_in = res_st_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_HEAPS; i++) begin
            cnt_ff[i] <= '0;
            flags_ff[i] <= '0;
            lo_ff[i] <= '0;
            hi_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         flags_ff <= flags_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;         h_ff <= h_in;           req_ff <= req_in;
      baddr_ff <= baddr_in;     size_ff <= size_in;     idx_ff <= idx_in;
      prev_ff <= prev_in;       best_ff <= best_in;     large_ff <= large_in;
      k_ff <= k_in;             kstart_ff <= kstart_in; kkind_ff <= kkind_in;
      ins_ff <= ins_in;         j_ff <= j_in;           a_ff <= a_in;
      b_ff <= b_in;             m_ff <= m_in;           off_ff <= off_in;
      pfree_ff <= pfree_in;     n_ff <= n_in;           w_ff <= w_in;
      run_ff <= run_in;         res_addr_ff <= res_addr_in;
      res_st_ff <= res_st_in;   rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;
   assign rsp_ch.status      = rsp_st_ff;

   // a taken command keeps the port closed until its response is queued
   `FFHB_ASSERT_NEXT(a_busy_after_accept, accept, !req_ch.ready)
   // table of the active heap never grows past its limit
   `FFHB_ASSERT_IMPL(a_count_bound, hvalid && state_ff != S_IDLE, cnt <= CNT_FULL)
   // a finishing command always leaves a response pending
   `FFHB_ASSERT_NEXT(a_done_posts, state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready),
                     rsp_ch.valid && req_ch.ready)
   // the ram is never read or written while waiting for a command
   `FFHB_ASSERT_IMPL(a_idle_quiet, state_ff == S_IDLE, !wr_en && !rd_en)

endmodule

// ===== dv/first_fit_heap_block_table_core_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_block_table_core_chk
// watches the command, response and register ports, keeps its own copy of the
// heap tables, predicts each response and compares it field by field
// ----------------------------------------------------------------------------
module first_fit_heap_block_table_core_chk
   import ffhb_pkg::*;
#(
   parameter int MAX_UNITS = 256,
   parameter int NUM_HEAPS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   ffhb_req_if                   req_ch,
   ffhb_rsp_if                   rsp_ch,
   input  logic                  csr_we,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0]     csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [ST_W-1:0]   status;
   } rsp_type;

   logic [ADDR_W-1:0] blk_start [NUM_HEAPS][MAX_UNITS+1];
   logic [1:0]        blk_kind  [NUM_HEAPS][MAX_UNITS+1];
   int unsigned       blk_count [NUM_HEAPS];
   logic [1:0]        hflags    [NUM_HEAPS];
   logic [ADDR_W-1:0] hlo       [NUM_HEAPS];
   logic [ADDR_W-1:0] hhi       [NUM_HEAPS];
   logic [ADDR_W-1:0] cfg_base  [CFG_HEAPS];
   logic [SIZE_W-1:0] cfg_size  [CFG_HEAPS];
   rsp_type           expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic logic [ADDR_W-1:0] blen(int h, int k);
      return blk_start[h][k+1] - blk_start[h][k];
   endfunction

   function automatic logic [ADDR_W-1:0] up16(logic [ADDR_W-1:0] v);
      return (v + 32'd15) & ~32'd15;
   endfunction

   function automatic int locate(int h, logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] off, o;
      int lo, hi, m;
      off = a - hlo[h];
      lo = 0;
      hi = blk_count[h];
      if (off >= hhi[h] - hlo[h]) return -1;
      while (lo < hi) begin
         m = lo + (hi - lo) / 2;
         o = blk_start[h][m] - hlo[h];
         if (o == off) return m;
         if (o < off) lo = m + 1;
         else hi = m;
      end
      return -1;
   endfunction

   function automatic void open_gap(int h, int k);
      for (int j = blk_count[h]; j > k; j--) begin
         blk_start[h][j+1] = blk_start[h][j];
         blk_kind[h][j+1]  = blk_kind[h][j];
      end
      blk_count[h]++;
   endfunction

   function automatic void close_gap(int h, int k, int n);
      for (int j = k; j + n <= blk_count[h]; j++) begin
         blk_start[h][j] = blk_start[h][j+n];
         blk_kind[h][j]  = blk_kind[h][j+n];
      end
      blk_count[h] -= n;
   endfunction

   function automatic logic [ST_W-1:0] first_fit(int h, logic [ADDR_W-1:0] sz,
                                                 output logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] s;
      a = '0;
      if (blk_count[h] >= MAX_UNITS - 1) return ST_FULL;
      sz = up16(sz);
      if (sz != 0)
         for (int k = 0; k < blk_count[h]; k++)
            if (blk_kind[h][k] == KIND_FREE && blen(h, k) >= sz) begin
               s = blk_start[h][k];
               if (blen(h, k) > sz) begin
                  open_gap(h, k);
                  blk_start[h][k+1] = s + sz;
                  blk_kind[h][k+1]  = KIND_FREE;
               end
               blk_kind[h][k] = KIND_USED;
               a = s;
               return ST_OK;
            end
      hflags[h][FLAG_FAILED] = 1'b1;
      return ST_NOFIT;
   endfunction

   function automatic void fold(int h);
      int w;
      bit in_run;
      w = 0;
      in_run = 0;
      for (int r = 0; r < blk_count[h]; r++) begin
         if (blk_kind[h][r] == KIND_USED) begin
            blk_start[h][w] = blk_start[h][r];
            blk_kind[h][w]  = KIND_USED;
            w++;
            in_run = 0;
         end else if (!in_run) begin
            in_run = 1;
            blk_start[h][w] = blk_start[h][r];
            blk_kind[h][w]  = KIND_FREE;
            w++;
         end
      end
      blk_start[h][w] = hhi[h];
      blk_kind[h][w]  = KIND_USED;
      blk_count[h] = w;
   endfunction

   function automatic rsp_type predict_command(logic [CMD_W-1:0] cmd, int h,
                                               logic [SIZE_W-1:0] rsz,
                                               logic [ADDR_W-1:0] ba);
      rsp_type r;
      logic [ADDR_W-1:0] b, s, best, sz;
      int k, at, n;
      r.addr = '0;
      r.status = ST_OK;
      if (h >= NUM_HEAPS) begin
         r.status = ST_NOTFOUND;
         return r;
      end
      case (cmd)
         CMD_INIT: begin
            b = h < CFG_HEAPS ? cfg_base[h] : '0;
            s = h < CFG_HEAPS ? ({8'd0, cfg_size[h]} & ~32'd15) : '0;
            hflags[h] = '0;
            hlo[h] = b;
            hhi[h] = b + s;
            blk_count[h] = 1;
            blk_start[h][0] = b;
            blk_kind[h][0]  = KIND_FREE;
            blk_start[h][1] = b + s;
            blk_kind[h][1]  = KIND_USED;
         end
         CMD_ALLOC: r.status = first_fit(h, {8'd0, rsz}, r.addr);
         CMD_LARGEST: begin
            best = '0;
            for (int j = 0; j < blk_count[h]; j++)
               if (blk_kind[h][j] == KIND_FREE && blen(h, j) > best) best = blen(h, j);
            r.status = first_fit(h, best, r.addr);
         end
         CMD_FREE: begin
            k = locate(h, ba);
            if (k < 0) r.status = ST_NOTFOUND;
            else if (blk_kind[h][k] == KIND_FREE) r.status = ST_STATE;
            else begin
               at = k;
               n = 0;
               blk_kind[h][k] = KIND_FREE;
               if (k > 0 && blk_kind[h][k-1] == KIND_FREE) n++;
               else at = k + 1;
               if (blk_kind[h][k+1] == KIND_FREE) n++;
               if (n != 0) close_gap(h, at, n);
            end
         end
         CMD_VOID: begin
            k = locate(h, ba);
            if (k < 0) r.status = ST_NOTFOUND;
            else begin
               blk_kind[h][k] = KIND_VOID;
               hflags[h][FLAG_VOIDED] = 1'b1;
            end
         end
         CMD_SHRINK: begin
            k = locate(h, ba);
            if (k < 0) r.status = ST_NOTFOUND;
            else if (blk_kind[h][k] != KIND_USED) r.status = ST_STATE;
            else begin
               sz = up16({8'd0, rsz});
               if (sz == 0 || sz >= blen(h, k)) r.status = ST_NOFIT;
               else if (blk_count[h] >= MAX_UNITS - 1) r.status = ST_FULL;
               else begin
                  open_gap(h, k);
                  r.addr = blk_start[h][k] + sz;
                  blk_start[h][k+1] = r.addr;
                  blk_kind[h][k+1]  = KIND_FREE;
               end
            end
         end
         CMD_CLEAR: begin
            if (hflags[h][FLAG_VOIDED]) fold(h);
            hflags[h] = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         expected_rsp.delete();
         for (int h = 0; h < NUM_HEAPS; h++) begin
            blk_count[h] = 0;
            hflags[h] = '0;
            hlo[h] = '0;
            hhi[h] = '0;
            blk_start[h][0] = '0;
            blk_kind[h][0] = KIND_FREE;
         end
         for (int i = 0; i < CFG_HEAPS; i++) begin
            cfg_base[i] = '0;
            cfg_size[i] = '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CFG_BASE0: cfg_base[0] = csr_wdata;
               CFG_SIZE0: cfg_size[0] = csr_wdata[SIZE_W-1:0];
               CFG_BASE1: cfg_base[1] = csr_wdata;
               CFG_SIZE1: cfg_size[1] = csr_wdata[SIZE_W-1:0];
               CFG_BASE2: cfg_base[2] = csr_wdata;
               CFG_SIZE2: cfg_size[2] = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.addr = rsp_ch.result_addr;
            got.status = rsp_ch.status;
            if (expected_rsp.size() == 0) begin
               $error("response transaction with nothing expected");
               errs++;
            end else begin
               want = expected_rsp.pop_front();
               if (got.addr !== want.addr) begin
                  $error("result_addr expected %h actual %h", want.addr, got.addr);
                  errs++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  errs++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_rsp.push_back(predict_command(req_ch.cmd, int'(req_ch.heap_select),
                                                   req_ch.req_size, req_ch.block_addr));
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== dv/first_fit_heap_block_table_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_block_table_core_tb
// drives heap commands and register writes, with random idle gaps unless no_idle;
// the checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module first_fit_heap_block_table_core_tb;
   import ffhb_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0] csr_wdata;
   int                fail_count;
   int                pending_count;
   bit                no_idle;
   logic [ADDR_W-1:0] live_addr [$];

   ffhb_req_if req_ch ();
   ffhb_rsp_if rsp_ch ();

   first_fit_heap_block_table_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   first_fit_heap_block_table_core_chk chk (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // receiver stalls
   always @(negedge clock)
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 29);

   // remember addresses handed out so later free/void/shrink can hit them
   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.result_addr != 0)
         live_addr.push_back(rsp_ch.result_addr);

   // valid stays high after a transaction until an idle gap or a drain drops it
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [HSEL_W-1:0] h,
                               logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ba);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.heap_select <= h;
      req_ch.req_size <= sz;
      req_ch.block_addr <= ba;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (1100) @(negedge clock);
   endtask

   task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
   endtask

   task automatic set_heaps(logic [ADDR_W-1:0] b0, logic [SIZE_W-1:0] s0,
                            logic [ADDR_W-1:0] b1, logic [SIZE_W-1:0] s1,
                            logic [ADDR_W-1:0] b2, logic [SIZE_W-1:0] s2);
      write_reg(CFG_BASE0, b0);
      write_reg(CFG_SIZE0, {8'd0, s0});
      write_reg(CFG_BASE1, b1);
      write_reg(CFG_SIZE1, {8'd0, s1});
      write_reg(CFG_BASE2, b2);
      write_reg(CFG_SIZE2, {8'd0, s2});
      csr_we <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] pick_addr();
      if (live_addr.size() != 0 && $urandom_range(9) < 8)
         return live_addr[$urandom_range(live_addr.size() - 1)];
      return $urandom;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(9))
         0: return SIZE_W'($urandom);
         1: return '0;
         2: return SIZE_W'($urandom_range(4095));
         default: return SIZE_W'($urandom_range(300));
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [CMD_W-1:0] cmd;
      logic [HSEL_W-1:0] h;
      int p;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(99);
         h = ($urandom_range(49) == 0) ? 2'd3 : HSEL_W'($urandom_range(2));
         if (p < 3) cmd = CMD_INIT;
         else if (p < 40) cmd = CMD_ALLOC;
         else if (p < 44) cmd = CMD_LARGEST;
         else if (p < 68) cmd = CMD_FREE;
         else if (p < 78) cmd = CMD_VOID;
         else if (p < 90) cmd = CMD_SHRINK;
         else if (p < 98) cmd = CMD_CLEAR;
         else cmd = 3'd7;
         send_command(cmd, h, pick_size(), pick_addr());
         if (live_addr.size() > 200) live_addr.delete();
      end
   endtask

   initial begin
      reset = 1'b1;
      no_idle = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_INIT;
      req_ch.heap_select = '0;
      req_ch.req_size = '0;
      req_ch.block_addr = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: uninitialized heap, bad heap select, unknown command
      send_command(CMD_ALLOC, 2'd0, 24'd16, '0);
      send_command(CMD_FREE, 2'd1, '0, 32'h0);
      send_command(CMD_SHRINK, 2'd2, 24'd16, 32'h0);
      send_command(CMD_CLEAR, 2'd3, 24'hFFFFFF, 32'hFFFFFFFF);
      send_command(3'd7, 2'd0, '0, '0);
      drain_responses();
      // heap 2 wraps past the top of the address space
      set_heaps(32'h0000_1000, 24'h00_0400, 32'hFFFF_FFFF, 24'hFF_FFFF,
                32'hFFFF_FF00, 24'h00_0207);
      for (int h = 0; h < 3; h++) send_command(CMD_INIT, HSEL_W'(h), '0, '0);
      send_command(CMD_ALLOC, 2'd0, 24'd0, '0);
      send_command(CMD_ALLOC, 2'd0, 24'd1, '0);
      send_command(CMD_ALLOC, 2'd0, 24'd17, '0);
      send_command(CMD_ALLOC, 2'd0, 24'hFFFFFF, '0);
      send_command(CMD_SHRINK, 2'd0, 24'd16, 32'h1010);
      send_command(CMD_SHRINK, 2'd0, 24'd0, 32'h1010);
      send_command(CMD_SHRINK, 2'd0, 24'd1, 32'h1000);
      send_command(CMD_FREE, 2'd0, '0, 32'h1000);
      send_command(CMD_FREE, 2'd0, '0, 32'h1000);
      send_command(CMD_VOID, 2'd0, '0, 32'h1010);
      send_command(CMD_FREE, 2'd0, '0, 32'h1010);
      send_command(CMD_ALLOC, 2'd2, 24'd300, '0);
      send_command(CMD_LARGEST, 2'd2, '0, '0);
      send_command(CMD_LARGEST, 2'd2, '0, '0);
      send_command(CMD_VOID, 2'd2, '0, 32'hFFFF_FF00);
      send_command(CMD_CLEAR, 2'd2, '0, '0);
      send_command(CMD_LARGEST, 2'd1, '0, '0);
      // hold off until everything is back
      drain_responses();

      // small heaps fill the table and exercise the full status
      set_heaps($urandom & ~32'hF, 24'h00_1000, 32'h8000_0000, 24'h00_2000,
                32'hFFFF_F000, 24'h00_3000);
      for (int h = 0; h < 3; h++) send_command(CMD_INIT, HSEL_W'(h), '0, '0);
      random_phase(400);
      drain_responses();

      no_idle = 1'b1;
      set_heaps($urandom, SIZE_W'($urandom), $urandom, 24'h00_0800, 32'h0, 24'h00_0000);
      for (int h = 0; h < 3; h++) send_command(CMD_INIT, HSEL_W'(h), '0, '0);
      random_phase(250);
      drain_responses();

      no_idle = 1'b0;
      set_heaps(32'hFFFF_FFF0, 24'hFF_FFF0, $urandom, 24'h00_0FFF, $urandom, 24'h00_4000);
      for (int h = 0; h < 3; h++) send_command(CMD_INIT, HSEL_W'(h), '0, '0);
      random_phase(500);
      drain_responses();

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ffhb_pkg.sv
hdl/ffhb_req_if.sv
hdl/ffhb_rsp_if.sv
hdl/ffhb_ram.sv
hdl/ffhb_csr.sv
hdl/first_fit_heap_block_table_core.sv
dv/first_fit_heap_block_table_core_chk.sv
dv/first_fit_heap_block_table_core_tb.sv
